FILE: src/hole_fit_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// hole fit allocator assertion macros
// shared assertion helpers, clocked on clk_i and off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef HOLE_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define HOLE_FIT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define HFA_ASSERT_NOW(label, cond, result, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |-> (result)) else $error(msg);

// next-cycle implication
`define HFA_ASSERT_NEXT(label, cond, result, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (result)) else $error(msg);

`endif

FILE: src/hfa_pkg.sv
// ----------------------------------------------------------------------------
// hfa_pkg
// types and codes shared by the hole fit allocator
// ----------------------------------------------------------------------------
package hfa_pkg;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // fit policy codes, the fourth code grants nothing
  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  // configuration register indexes
  localparam logic CFG_FIT_POLICY   = 1'b0;
  localparam logic CFG_HOLES_IN_USE = 1'b1;

  localparam int unsigned CfgDataW = 5;

  typedef struct packed {
    logic        kind;
    logic [3:0]  hole_index;
    logic [15:0] size_value;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  block_index;
    logic [15:0] remaining_size;
  } out_item_t;

endpackage

FILE: src/hfa_ram.sv
// ----------------------------------------------------------------------------
// hfa_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hfa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/hole_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// hole_fit_allocator_core
// first, best and worst fit allocation over a table of free hole sizes
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | direction | moves
//  ---------+----------------------------------+-----------+-----------------------
//  in       | in_valid_i in_ready_o in_data_i  | sink      | load or request item
//  out      | out_valid_o out_ready_i out_data_o | source  | one result per request
//  cfg      | cfg_we_i cfg_idx_i cfg_data_i    | sink      | register write, no wait
//
//  a load transfer writes the hole table in its accepting cycle; loads go back to back
//  a request scans span = min(holes_in_use, NUM_HOLES) entries: the span reads,
//  the compare of the last entry, a check that the read pipe is empty, then the
//  registered result and its write-back in finish; a zero span skips reads and compares
//  in_ready_o is low meanwhile; write-back stalls only while an older result waits
//  reset clears control state only, the hole table holds nothing until loaded
//
// ----------------------------------------------------------------------------
`include "hole_fit_allocator_core_defines.svh"

module hole_fit_allocator_core #(
  parameter int unsigned NUM_HOLES = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hfa_pkg::in_item_t             in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hfa_pkg::out_item_t            out_data_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [hfa_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;
  localparam int unsigned CntW = $clog2(NUM_HOLES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e                 state_q;
  logic [1:0]             policy_q;
  logic [4:0]             holes_in_use_q;
  logic [SIZE_BITS-1:0]   size_q;
  logic [CntW-1:0]        span_q;
  logic [CntW-1:0]        issue_q;    // next table entry to read
  logic [IdxW-1:0]        cmp_idx_q;  // entry whose data is on the ram output
  logic                   pend_q;     // ram output carries a valid entry
  logic                   found_q;
  logic [IdxW-1:0]        pick_q;
  logic [SIZE_BITS-1:0]   best_q;
  logic                   out_valid_q;
  hfa_pkg::out_item_t     out_q;

  // ram signals
  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  logic [SIZE_BITS-1:0]   ram_wdata;
  logic                   ram_re;
  logic [SIZE_BITS-1:0]   ram_rdata;

  logic                   in_xfer;
  logic                   load_ok;
  logic [8:0]             load_idx_ext;
  logic                   out_free;
  logic                   fits;
  logic                   take;
  logic                   grant;
  logic [SIZE_BITS-1:0]   remaining;
  logic [CntW-1:0]        span_d;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_xfer      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign load_idx_ext = 9'(in_data_i.hole_index);
  assign load_ok      = load_idx_ext < 9'(NUM_HOLES);

  // entries beyond the table are never searched
  assign span_d = (9'(holes_in_use_q) > 9'(NUM_HOLES)) ? CntW'(NUM_HOLES)
                                                       : CntW'(holes_in_use_q);

  // compare the entry on the ram output against the running candidate
  assign fits = ram_rdata >= size_q;
  always_comb begin
    take = 1'b0;
    unique case (policy_q)
      hfa_pkg::POLICY_FIRST: take = fits && !found_q;
      // strict compare keeps the lowest index on a tie
      hfa_pkg::POLICY_BEST:  take = fits && (!found_q || ram_rdata < best_q);
      // non-strict compare moves to the highest index on a tie
      hfa_pkg::POLICY_WORST: take = !found_q || ram_rdata >= best_q;
      default:               take = 1'b0;
    endcase
  end

  // worst fit tracks the largest hole and checks the request only at the end
  always_comb begin
    grant = 1'b0;
    unique case (policy_q)
      hfa_pkg::POLICY_FIRST,
      hfa_pkg::POLICY_BEST:  grant = found_q;
      hfa_pkg::POLICY_WORST: grant = found_q && (best_q >= size_q);
      default:               grant = 1'b0;
    endcase
  end

  assign remaining = best_q - size_q;

  // single write port: loads in idle, write-back of a granted result when it is registered
  always_comb begin
    if (state_q == ST_FINISH) begin
      ram_we    = out_free && grant;
      ram_waddr = pick_q;
      ram_wdata = remaining;
    end else begin
      ram_we    = in_xfer && (in_data_i.kind == hfa_pkg::KIND_LOAD) && load_ok;
      ram_waddr = load_idx_ext[IdxW-1:0];
      ram_wdata = SIZE_BITS'(in_data_i.size_value);
    end
  end

  assign ram_re = (state_q == ST_SCAN) && (issue_q < span_q);

  hfa_ram #(
    .Width (SIZE_BITS),
    .Depth (NUM_HOLES)
  ) u_hole_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      policy_q       <= hfa_pkg::POLICY_FIRST;
      holes_in_use_q <= 5'd16;
      issue_q        <= '0;
      pend_q         <= 1'b0;
      found_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      // configuration must arrive only while idle; the core itself does not enforce it
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hfa_pkg::CFG_FIT_POLICY:   policy_q       <= cfg_data_i[1:0];
          hfa_pkg::CFG_HOLES_IN_USE: holes_in_use_q <= cfg_data_i;
          default: ;
        endcase
      end

      // in finish the result register is refilled below instead
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer && (in_data_i.kind == hfa_pkg::KIND_REQUEST)) begin
            size_q  <= SIZE_BITS'(in_data_i.size_value);
            span_q  <= span_d;
            issue_q <= '0;
            pend_q  <= 1'b0;
            found_q <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_q    <= ram_re;
          cmp_idx_q <= issue_q[IdxW-1:0];
          if (ram_re) begin
            issue_q <= issue_q + CntW'(1);
          end
          if (pend_q && take) begin
            found_q <= 1'b1;
            pick_q  <= cmp_idx_q;
            best_q  <= ram_rdata;
          end
          if (!ram_re && !pend_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_q.granted        <= grant;
            out_q.block_index    <= grant ? 4'(pick_q) : 4'd0;
            out_q.remaining_size <= grant ? 16'(remaining) : 16'd0;
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks on the scan and write-back sequencing
  `HFA_ASSERT_NOW(a_no_write_in_scan, state_q == ST_SCAN, !ram_we, "ram write during scan")
  `HFA_ASSERT_NOW(a_issue_in_span, state_q == ST_SCAN, issue_q <= span_q, "scan ran past span")
  `HFA_ASSERT_NEXT(a_pend_from_read, ram_re, pend_q, "lost ram read in scan")
  `HFA_ASSERT_NOW(a_refused_is_zero, out_valid_q && !out_q.granted,
    out_q.block_index == 4'd0 && out_q.remaining_size == 16'd0, "refused result not zero")

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// hole fit allocator testbench
// drives load and request transfers into hole_fit_allocator_core under every
// fit policy and a range of search widths, predicts each grant from a private
// copy of the hole table and checks every result transfer field by field
// ----------------------------------------------------------------------------

class hole_table_model;
  logic [15:0]        hole_size [16];
  logic [1:0]         policy;
  logic [4:0]         span_cfg;
  hfa_pkg::out_item_t pending_grants [$];
  int                 errors;

  function new();
    policy   = hfa_pkg::POLICY_FIRST;
    span_cfg = 5'd16;
    errors   = 0;
    foreach (hole_size[i]) hole_size[i] = '0;
  endfunction

  function void write_reg(input logic idx, input logic [4:0] value);
    if (idx == hfa_pkg::CFG_FIT_POLICY) policy = value[1:0];
    else span_cfg = value;
  endfunction

  function int pending_count();
    return pending_grants.size();
  endfunction

  // loads update the table, requests search it and queue the grant
  function void take_item(input hfa_pkg::in_item_t item);
    int                 span;
    int                 pick;
    bit                 found;
    bit                 any;
    hfa_pkg::out_item_t grant;
    if (item.kind == hfa_pkg::KIND_LOAD) begin
      hole_size[item.hole_index] = item.size_value;
      return;
    end
    span  = (span_cfg > 5'd16) ? 16 : int'(span_cfg);
    pick  = 0;
    found = 1'b0;
    any   = 1'b0;
    case (policy)
      hfa_pkg::POLICY_FIRST: begin
        for (int i = 0; i < span; i++)
          if (!found && hole_size[i] >= item.size_value) begin
            pick  = i;
            found = 1'b1;
          end
      end
      hfa_pkg::POLICY_BEST: begin
        for (int i = 0; i < span; i++)
          if (hole_size[i] >= item.size_value && (!found || hole_size[i] < hole_size[pick]))
          begin
            pick  = i;
            found = 1'b1;
          end
      end
      hfa_pkg::POLICY_WORST: begin
        for (int i = 0; i < span; i++)
          if (!any || hole_size[i] >= hole_size[pick]) begin
            pick = i;
            any  = 1'b1;
          end
        found = any && (hole_size[pick] >= item.size_value);
      end
      default: found = 1'b0;
    endcase
    if (found) begin
      hole_size[pick]      = hole_size[pick] - item.size_value;
      grant.granted        = 1'b1;
      grant.block_index    = pick[3:0];
      grant.remaining_size = hole_size[pick];
    end else begin
      grant = '0;
    end
    pending_grants = {pending_grants, grant};
  endfunction

  function void check_grant(input hfa_pkg::out_item_t got);
    hfa_pkg::out_item_t want;
    if (pending_grants.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_grants.pop_front();
    if (got.granted !== want.granted) begin
      $display("%0t: granted mismatch, expected %0d, actual %0d",
               $time, want.granted, got.granted);
      errors++;
    end
    if (got.block_index !== want.block_index) begin
      $display("%0t: block_index mismatch, expected %0d, actual %0d",
               $time, want.block_index, got.block_index);
      errors++;
    end
    if (got.remaining_size !== want.remaining_size) begin
      $display("%0t: remaining_size mismatch, expected %0d, actual %0d",
               $time, want.remaining_size, got.remaining_size);
      errors++;
    end
  endfunction
endclass

module testbench;

  // settling time after the last grant, with margin over a full-table request
  localparam int DRAIN_CYCLES   = 25;
  localparam int SETTINGS_PER_PHASE = 4;
  localparam int ITEMS_PER_SETTING  = 78;
  // the fourth policy code has no name in the package and grants nothing
  localparam logic [1:0] POLICY_NONE = 2'd3;

  logic                         clk_i;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready_o;
  hfa_pkg::in_item_t            in_data   = '0;
  logic                         out_valid_o;
  logic                         out_ready = 1'b0;
  hfa_pkg::out_item_t           out_data_o;
  logic                         cfg_we    = 1'b0;
  logic                         cfg_idx   = hfa_pkg::CFG_FIT_POLICY;
  logic [hfa_pkg::CfgDataW-1:0] cfg_data  = '0;

  // idling odds, in percent per cycle
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  hole_table_model alloc_model = new();

  hole_fit_allocator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side, ready drops at random according to stall_pct
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // transfer monitor: results are checked before the new item is noted, as a
  // result can never belong to a request accepted on the same edge
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid_o && out_ready) alloc_model.check_grant(out_data_o);
      if (in_valid && in_ready_o) alloc_model.take_item(in_data);
    end
  end

  // one item transfer; valid stays high into the next item unless a gap is
  // rolled, so it is never lowered and raised on the same edge
  task automatic send_item(input hfa_pkg::in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic load_hole(input logic [3:0] idx, input logic [15:0] value);
    send_item('{kind: hfa_pkg::KIND_LOAD, hole_index: idx, size_value: value});
  endtask

  task automatic request_size(input logic [15:0] value);
    send_item('{kind: hfa_pkg::KIND_REQUEST, hole_index: 4'($urandom_range(15)),
                size_value: value});
  endtask

  // stop sending, wait for every outstanding grant, then let the core settle
  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    while (alloc_model.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // both registers are written back to back while the core is idle
  task automatic set_config(input logic [1:0] policy, input logic [4:0] holes);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= hfa_pkg::CFG_FIT_POLICY;
    cfg_data <= hfa_pkg::CfgDataW'(policy);
    @(posedge clk_i);
    alloc_model.write_reg(hfa_pkg::CFG_FIT_POLICY, hfa_pkg::CfgDataW'(policy));
    cfg_idx  <= hfa_pkg::CFG_HOLES_IN_USE;
    cfg_data <= holes;
    @(posedge clk_i);
    alloc_model.write_reg(hfa_pkg::CFG_HOLES_IN_USE, holes);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // hard stop in case the core hangs
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    hfa_pkg::in_item_t item;
    int unsigned       roll;
    logic [4:0]        holes;

    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // fill the whole table first so that no search ever reads an empty entry
    for (int i = 0; i < 16; i++) load_hole(4'(i), 16'(i * 100 + 50));
    load_hole(4'd0, 16'd0);
    load_hole(4'd15, 16'hFFFF);
    load_hole(4'd7, 16'd350);

    // reset settings: first fit over all sixteen holes
    request_size(16'd0);          // zero request lands on an empty hole
    request_size(16'hFFFF);       // only the top hole fits, it empties
    request_size(16'hFFFF);       // nothing fits any more

    // best fit, equal smallest holes go to the lower index
    set_config(hfa_pkg::POLICY_BEST, 5'd16);
    request_size(16'd300);
    request_size(16'd340);

    // worst fit, equal largest holes go to the higher index
    set_config(hfa_pkg::POLICY_WORST, 5'd16);
    request_size(16'd1450);
    load_hole(4'd2, 16'd1350);
    request_size(16'd1);
    request_size(16'd2000);       // largest hole too small, no grant

    set_config(POLICY_NONE, 5'd16);
    request_size(16'd0);

    // nothing searched at all
    set_config(hfa_pkg::POLICY_FIRST, 5'd0);
    request_size(16'd0);

    // a load outside the searched span is kept for later
    set_config(hfa_pkg::POLICY_FIRST, 5'd1);
    load_hole(4'd9, 16'd60000);
    request_size(16'd100);

    // oversized span saturates to the table size
    set_config(hfa_pkg::POLICY_FIRST, 5'd31);
    request_size(16'd60000);
    set_config(hfa_pkg::POLICY_WORST, 5'd17);
    request_size(16'd0);

    // random part, four idling phases each with several settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        case ($urandom_range(3))
          0:       holes = 5'd16;
          1:       holes = 5'($urandom_range(31));
          2:       holes = 5'($urandom_range(16, 31));
          default: holes = 5'($urandom_range(1, 16));
        endcase
        set_config(2'($urandom_range(3)), holes);
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          // hold off until every grant is back, once per phase
          if (s == 1 && n == ITEMS_PER_SETTING / 2) drain();
          item.hole_index = 4'($urandom_range(15));
          roll = $urandom_range(9);
          if ($urandom_range(99) < 60) begin
            item.kind = hfa_pkg::KIND_REQUEST;
            // mostly small requests so that holes keep granting
            if (roll < 5)      item.size_value = 16'($urandom_range(255));
            else if (roll < 8) item.size_value = 16'($urandom_range(4095));
            else               item.size_value = 16'($urandom_range(65535));
          end else begin
            item.kind = hfa_pkg::KIND_LOAD;
            if (roll < 7) item.size_value = 16'($urandom_range(65535));
            else          item.size_value = 16'($urandom_range(255));
          end
          send_item(item);
        end
      end
    end

    drain();
    if (alloc_model.errors == 0 && alloc_model.pending_count() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/hfa_pkg.sv
src/hfa_ram.sv
src/hole_fit_allocator_core.sv
tb/testbench.sv
